FILE: hdl/crng_pkg.sv
// Package for the combined LCG shuffle generator: payload structs, CSR and queue types,
// sequencer states, generator constants and the modular arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package crng_pkg;

   localparam logic [31:0] CRNG_MOD_ONE  = 32'd2147483563;
   localparam logic [31:0] CRNG_MOD_TWO  = 32'd2147483399;
   localparam logic [15:0] CRNG_MUL_ONE  = 16'd40014;
   localparam logic [15:0] CRNG_MUL_TWO  = 16'd40692;
   // 2^31 minus each modulus, used to fold the high part of a product.
   localparam logic [7:0]  CRNG_FOLD_ONE = 8'd85;
   localparam logic [7:0]  CRNG_FOLD_TWO = 8'd249;
   localparam int          CRNG_WARMUPS  = 8;

   localparam logic CRNG_REQ_DRAW     = 1'b0;
   localparam logic CRNG_REQ_MODULATE = 1'b1;

   localparam logic CRNG_CSR_SEED     = 1'b0;
   localparam logic CRNG_CSR_FALLBACK = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] range_max;
      logic [30:0] modulate_amount;
   } req_payload_type;

   typedef struct packed {
      logic [30:0] raw_value;
      logic [31:0] bounded_value;
      logic        low_bit;
   } rsp_payload_type;

   // Classified item as it sits in the queue between front and back.
   typedef struct packed {
      logic        is_modulate;
      logic [31:0] range_max;
      logic [30:0] amount_one;
      logic [30:0] amount_two;
   } cmd_type;

   typedef struct packed {
      logic [30:0] seed;
      logic [30:0] fallback_seed;
      logic        seed_written;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB,
      ST_DRAW_START,
      ST_INIT_MUL,
      ST_INIT_RED,
      ST_MUL,
      ST_RED,
      ST_SLOT,
      ST_READ,
      ST_CALC,
      ST_MODULO,
      ST_EMIT
   } state_type;

   // Reduces a 47-bit product modulo 2^31 - fold. One fold and one subtract suffice.
   function automatic logic [30:0] crng_reduce(input logic [46:0] prod,
                                               input logic [7:0]  fold,
                                               input logic [31:0] modulus);
      logic [31:0] sum;
      begin
         sum = ({16'd0, prod[46:31]} * {24'd0, fold}) + {1'b0, prod[30:0]};
         if (sum >= modulus) begin
            sum = sum - modulus;
         end
         return sum[30:0];
      end
   endfunction

   // Reduces a value below twice the modulus.
   function automatic logic [30:0] crng_wrap(input logic [30:0] value,
                                             input logic [31:0] modulus);
      logic [31:0] v;
      begin
         v = {1'b0, value};
         if (v >= modulus) begin
            v = v - modulus;
         end
         return v[30:0];
      end
   endfunction

   // (state - amount) mod modulus, with the amount already reduced.
   function automatic logic [30:0] crng_sub(input logic [30:0] state,
                                            input logic [30:0] amount,
                                            input logic [31:0] modulus);
      logic [31:0] b;
      logic [31:0] r;
      begin
         b = {1'b0, crng_wrap(state, modulus)};
         if (b >= {1'b0, amount}) begin
            r = b - {1'b0, amount};
         end else begin
            r = b + modulus - {1'b0, amount};
         end
         return r[30:0];
      end
   endfunction

endpackage

FILE: hdl/crng_front.sv
// Front end: accepts request transfers, reduces the modulate amount for each generator
// and holds the classified items in a two-entry queue. Depends on crng_pkg.
`timescale 1ns / 1ps

module crng_front
   import crng_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            cmd_valid,
   output cmd_type         cmd_data,
   input  logic            cmd_pop
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;
   logic        pop;
   cmd_type     cmd_new;

   assign req_stall = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = entry_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      cmd_new.is_modulate = (req_payload.req_type == CRNG_REQ_MODULATE);
      cmd_new.range_max   = req_payload.range_max;
      cmd_new.amount_one  = crng_wrap(req_payload.modulate_amount, CRNG_MOD_ONE);
      cmd_new.amount_two  = crng_wrap(req_payload.modulate_amount, CRNG_MOD_TWO);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: hdl/crng_back.sv
// Back end: sequencer that initializes the generators, runs draws through the shuffle
// table memory, reduces the output by range_max and drives the result register.
// Depends on crng_pkg.
`timescale 1ns / 1ps

module crng_back
   import crng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            cmd_valid,
   input  cmd_type         cmd_data,
   output logic            cmd_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int QB = $clog2(TABLE_SIZE) + 1;
   localparam int RW = 31 + QB;
   localparam int JW = $clog2(TABLE_SIZE + CRNG_WARMUPS);
   localparam logic [31:0] SLOT_DIV = 32'(1 + (CRNG_MOD_ONE - 1) / TABLE_SIZE);
   localparam logic [QB-1:0] SLOT_RECIP = QB'((64'd1 << 31) / 64'(SLOT_DIV));

   logic [30:0]     table_mem [TABLE_SIZE];
   logic [30:0]     rd_data_ff;

   state_type       state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   logic            phase_ff, phase_in;
   logic            pending_ff, pending_in;
   logic [30:0]     gen_one_ff, gen_one_in;
   logic [30:0]     gen_two_ff, gen_two_in;
   logic [30:0]     out_ff, out_in;
   logic [46:0]     prod_one_ff, prod_one_in;
   logic [46:0]     prod_two_ff, prod_two_in;
   logic [JW-1:0]   step_ff, step_in;
   logic [RW-1:0]   div_rem_ff, div_rem_in;
   logic [QB-1:0]   div_q_ff, div_q_in;
   logic [AW-1:0]   slot_ff, slot_in;
   logic [31:0]     mod_rem_ff, mod_rem_in;
   logic [30:0]     mod_src_ff, mod_src_in;
   logic [4:0]      mod_cnt_ff, mod_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [30:0]     wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   logic [30:0]     start_seed;
   logic [30:0]     init_value;
   logic [RW-1:0]   slot_prod;
   logic [QB-1:0]   slot_clamped;
   logic [32:0]     diff;
   logic [32:0]     diff_adj;
   logic [32:0]     mod_shift;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff || cfg.seed_written;
      gen_one_in   = gen_one_ff;
      gen_two_in   = gen_two_ff;
      out_in       = out_ff;
      prod_one_in  = prod_one_ff;
      prod_two_in  = prod_two_ff;
      step_in      = step_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      slot_in      = slot_ff;
      mod_rem_in   = mod_rem_ff;
      mod_src_in   = mod_src_ff;
      mod_cnt_in   = mod_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = gen_one_ff;
      rd_en        = 1'b0;

      start_seed = (cfg.seed != 31'd0) ? cfg.seed : cfg.fallback_seed;
      if (start_seed == 31'd0) begin
         start_seed = 31'd1;
      end
      init_value   = crng_reduce(prod_one_ff, CRNG_FOLD_ONE, CRNG_MOD_ONE);
      slot_prod    = RW'(out_ff) * RW'(SLOT_RECIP);
      slot_clamped = (div_q_ff >= QB'(TABLE_SIZE)) ? QB'(TABLE_SIZE - 1) : div_q_ff;
      rd_addr      = slot_clamped[AW-1:0];
      diff         = {2'b00, rd_data_ff} - {2'b00, gen_two_ff};
      diff_adj     = (diff[32] || diff == 33'd0) ? diff + 33'(CRNG_MOD_ONE - 1) : diff;
      mod_shift    = {mod_rem_ff, mod_src_ff[30]};

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               phase_in = 1'b0;
               state_in = cmd_data.is_modulate ? ST_SUB : ST_DRAW_START;
            end
         end
         ST_SUB: begin
            if (!phase_ff) begin
               gen_two_in = crng_sub(gen_two_ff, cmd_ff.amount_two, CRNG_MOD_TWO);
            end else begin
               gen_one_in = crng_sub(gen_one_ff, cmd_ff.amount_one, CRNG_MOD_ONE);
            end
            state_in = ST_DRAW_START;
         end
         ST_DRAW_START: begin
            if (pending_ff) begin
               gen_one_in = start_seed;
               gen_two_in = start_seed;
               step_in    = JW'(TABLE_SIZE + CRNG_WARMUPS - 1);
               pending_in = 1'b0;
               state_in   = ST_INIT_MUL;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_INIT_MUL: begin
            prod_one_in = {16'd0, gen_one_ff} * {31'd0, CRNG_MUL_ONE};
            state_in    = ST_INIT_RED;
         end
         ST_INIT_RED: begin
            gen_one_in = init_value;
            if (step_ff < JW'(TABLE_SIZE)) begin
               wr_en   = 1'b1;
               wr_addr = step_ff[AW-1:0];
               wr_data = init_value;
            end
            if (step_ff == '0) begin
               // The last entry written is slot 0, which seeds the shuffle output.
               out_in   = init_value;
               state_in = ST_MUL;
            end else begin
               step_in  = step_ff - 1'b1;
               state_in = ST_INIT_MUL;
            end
         end
         ST_MUL: begin
            prod_one_in = {16'd0, gen_one_ff} * {31'd0, CRNG_MUL_ONE};
            prod_two_in = {16'd0, gen_two_ff} * {31'd0, CRNG_MUL_TWO};
            // The reciprocal estimate of the slot is exact or one below.
            div_q_in    = slot_prod[RW-1:31];
            state_in    = ST_RED;
         end
         ST_RED: begin
            gen_one_in = crng_reduce(prod_one_ff, CRNG_FOLD_ONE, CRNG_MOD_ONE);
            gen_two_in = crng_reduce(prod_two_ff, CRNG_FOLD_TWO, CRNG_MOD_TWO);
            div_rem_in = RW'(out_ff) - RW'(div_q_ff) * RW'(SLOT_DIV[30:0]);
            state_in   = ST_SLOT;
         end
         ST_SLOT: begin
            if (div_rem_ff >= RW'(SLOT_DIV[30:0])) begin
               div_q_in = div_q_ff + 1'b1;
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            slot_in  = rd_addr;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            wr_data = gen_one_ff;
            out_in  = diff_adj[30:0];
            if (cmd_ff.is_modulate) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               mod_rem_in = 32'd0;
               mod_src_in = diff_adj[30:0];
               mod_cnt_in = 5'd30;
               state_in   = ST_MODULO;
            end
         end
         ST_MODULO: begin
            if (mod_shift >= {1'b0, cmd_ff.range_max}) begin
               mod_rem_in = 32'(mod_shift - {1'b0, cmd_ff.range_max});
            end else begin
               mod_rem_in = mod_shift[31:0];
            end
            mod_src_in = {mod_src_ff[29:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == 5'd0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.raw_value     = out_ff;
               rsp_in.bounded_value = (cmd_ff.range_max == 32'd0) ? 32'd0 : mod_rem_ff;
               rsp_in.low_bit       = out_ff[0];
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         gen_one_ff   <= 31'd0;
         gen_two_ff   <= 31'd0;
         out_ff       <= 31'd0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_one_ff   <= gen_one_in;
         gen_two_ff   <= gen_two_in;
         out_ff       <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      phase_ff    <= phase_in;
      prod_one_ff <= prod_one_in;
      prod_two_ff <= prod_two_in;
      step_ff     <= step_in;
      div_rem_ff  <= div_rem_in;
      div_q_ff    <= div_q_in;
      slot_ff     <= slot_in;
      mod_rem_ff  <= mod_rem_in;
      mod_src_ff  <= mod_src_in;
      mod_cnt_ff  <= mod_cnt_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

endmodule

FILE: hdl/combined_lcg_shuffle_rng.sv
// Top level of the combined LCG generator with shuffle table: CSR port, front queue
// and back sequencer. Depends on crng_pkg, crng_front and crng_back.
//
// Requests arrive on the req_ channel (valid/stall); a transfer happens when req_valid
// is high and req_stall is low. A draw request yields one rsp_ transfer carrying the
// raw value, the value modulo range_max (0 when range_max is 0) and its low bit. A
// modulate request subtracts its amount from both generators, runs two draws and
// yields no result. A two-entry queue takes requests while the back end works.
// A draw passes from its request transfer to rsp_valid through the queue, the LCG
// step of both generators (multiply, then fold) under which the slot division by
// reciprocal runs, a slot correction step, a table read and write, and a bit-serial
// restoring modulo by range_max, which dominates. Items run one at a time, so the
// back end takes no new item before the current one is done. A modulate runs two
// draws without the modulo. After reset or a write to the seed register, the next draw
// first runs initialization: TABLE_SIZE+8 gen_one steps that fill the table memory.
// While rsp_stall is high the result register holds; the back end finishes its
// current item and waits before loading the next result.
// Registers: seed at byte 0, fallback_seed at byte 4. Reset clears the queue and
// the result valid flag and makes initialization pending.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng
   import crng_pkg::*;
#(
   parameter int TABLE_SIZE = 32
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   logic [30:0] seed_ff, seed_in;
   logic [30:0] fallback_ff, fallback_in;
   logic        csr_write;
   logic        seed_write;
   cfg_type     cfg;
   logic        cmd_valid;
   cmd_type     cmd_data;
   logic        cmd_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign seed_write = csr_write && (csr_paddr[2] == CRNG_CSR_SEED);

   always_comb begin
      seed_in     = seed_write ? csr_pwdata[30:0] : seed_ff;
      fallback_in = (csr_write && csr_paddr[2] == CRNG_CSR_FALLBACK) ?
                    csr_pwdata[30:0] : fallback_ff;
      csr_prdata  = (csr_paddr[2] == CRNG_CSR_SEED) ? {1'b0, seed_ff} : {1'b0, fallback_ff};
      cfg.seed          = seed_ff;
      cfg.fallback_seed = fallback_ff;
      cfg.seed_written  = seed_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= 31'd1;
         fallback_ff <= 31'd1;
      end else begin
         seed_ff     <= seed_in;
         fallback_ff <= fallback_in;
      end
   end

   crng_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   crng_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for combined_lcg_shuffle_rng: predicts each draw with a local
// model of the two generators and the shuffle table, and checks every result transfer.
// Depends on crng_pkg and the combined_lcg_shuffle_rng RTL.
`timescale 1ns / 1ps

module tb_top;
   import crng_pkg::*;

   localparam int TBL = 32;
   localparam logic [31:0] M1 = 32'd2147483563;
   localparam logic [31:0] M2 = 32'd2147483399;
   localparam logic [31:0] SLOT_DIV = 32'd1 + (M1 - 32'd1) / TBL;
   localparam logic [2:0] ADDR_SEED = 3'd0;
   localparam logic [2:0] ADDR_FALLBACK = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Predictor state.
   logic [30:0] pr_seed, pr_fallback, pr_gen_one, pr_gen_two, pr_out;
   logic [30:0] pr_table [TBL];
   bit pr_init_pending;

   rsp_payload_type expected_draws [$];
   int errors = 0;
   int draws_checked = 0;
   int modulates_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   combined_lcg_shuffle_rng i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [30:0] lcg_next(logic [30:0] z, logic [31:0] mul,
                                            logic [31:0] modulus);
      logic [63:0] p;
      p = 64'(z) * 64'(mul);
      return 31'(p % 64'(modulus));
   endfunction

   function automatic logic [30:0] sub_wrap(logic [30:0] g, logic [30:0] amt,
                                            logic [31:0] modulus);
      logic [31:0] a, b;
      a = 32'(amt) % modulus;
      b = 32'(g) % modulus;
      return (b >= a) ? 31'(b - a) : 31'(b + modulus - a);
   endfunction

   task automatic shuffle_draw();
      logic [30:0] s;
      logic [31:0] slot;
      longint v;
      if (pr_init_pending) begin
         s = pr_seed;
         if (s == 0) s = pr_fallback;
         if (s == 0) s = 31'd1;
         pr_gen_one = s;
         pr_gen_two = s;
         for (int j = TBL + 7; j >= 0; j--) begin
            pr_gen_one = lcg_next(pr_gen_one, 32'd40014, M1);
            if (j < TBL) pr_table[j] = pr_gen_one;
         end
         pr_out = pr_table[0];
         pr_init_pending = 0;
      end
      pr_gen_one = lcg_next(pr_gen_one, 32'd40014, M1);
      pr_gen_two = lcg_next(pr_gen_two, 32'd40692, M2);
      slot = 32'(pr_out) / SLOT_DIV;
      if (slot >= TBL) slot = TBL - 1;
      v = longint'(pr_table[slot]) - longint'(pr_gen_two);
      pr_table[slot] = pr_gen_one;
      if (v < 1) v += longint'(M1 - 1);
      pr_out = 31'(v);
   endtask

   task automatic predict_request(req_payload_type r);
      rsp_payload_type e;
      if (r.req_type == CRNG_REQ_MODULATE) begin
         pr_gen_two = sub_wrap(pr_gen_two, r.modulate_amount, M2);
         shuffle_draw();
         pr_gen_one = sub_wrap(pr_gen_one, r.modulate_amount, M1);
         shuffle_draw();
         modulates_sent++;
      end else begin
         shuffle_draw();
         e.raw_value = pr_out;
         e.bounded_value = (r.range_max == 0) ? 32'd0 : 32'(pr_out) % r.range_max;
         e.low_bit = pr_out[0];
         expected_draws.push_back(e);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_draws.size() == 0) begin
            report_mismatch("unexpected result raw_value", 32'(rsp_payload.raw_value), 0);
         end else begin
            rsp_payload_type e;
            e = expected_draws.pop_front();
            if (rsp_payload.raw_value !== e.raw_value)
               report_mismatch("raw_value", 32'(rsp_payload.raw_value), 32'(e.raw_value));
            if (rsp_payload.bounded_value !== e.bounded_value)
               report_mismatch("bounded_value", rsp_payload.bounded_value, e.bounded_value);
            if (rsp_payload.low_bit !== e.low_bit)
               report_mismatch("low_bit", 32'(rsp_payload.low_bit), 32'(e.low_bit));
            draws_checked++;
         end
      end
   end

   // Receiver stall generator; a nonzero hold count keeps the result channel stalled.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_request(req_payload_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      // A trailing modulate produces no result; let it finish.
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_SEED) begin
         pr_seed = data[30:0];
         pr_init_pending = 1;
      end else begin
         pr_fallback = data[30:0];
      end
   endtask

   function automatic req_payload_type make_draw(logic [31:0] range_max);
      req_payload_type r;
      r.req_type = CRNG_REQ_DRAW;
      r.range_max = range_max;
      r.modulate_amount = 31'($urandom);
      return r;
   endfunction

   function automatic req_payload_type make_modulate(logic [30:0] amount);
      req_payload_type r;
      r.req_type = CRNG_REQ_MODULATE;
      r.range_max = $urandom;
      r.modulate_amount = amount;
      return r;
   endfunction

   function automatic logic [31:0] random_range();
      case ($urandom_range(3))
         0: return 32'($urandom_range(16));
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return 32'd1 << $urandom_range(31);
      endcase
   endfunction

   task automatic test_directed();
      csr_write(ADDR_SEED, 32'd0);
      csr_write(ADDR_FALLBACK, 32'd0);
      send_request(make_draw(32'd0));
      send_request(make_draw(32'hFFFF_FFFF));
      send_request(make_draw(32'd1));
      send_request(make_draw(32'd2));
      wait_drained();
      csr_write(ADDR_FALLBACK, 32'h7FFF_FFFF);
      csr_write(ADDR_SEED, 32'd0);
      send_request(make_modulate(31'd5));
      send_request(make_draw(32'd1000));
      send_request(make_modulate(31'h7FFF_FFFF));
      send_request(make_modulate(31'd0));
      send_request(make_modulate(31'd2147483562));
      send_request(make_draw(32'h8000_0000));
      wait_drained();
      // Seeds at and above each modulus.
      csr_write(ADDR_SEED, 32'(M1));
      send_request(make_draw(32'd7));
      send_request(make_draw(32'd3));
      wait_drained();
      csr_write(ADDR_SEED, 32'(M2));
      send_request(make_draw(32'd7));
      send_request(make_draw(32'd3));
      wait_drained();
      csr_write(ADDR_SEED, 32'h7FFF_FFFF);
      send_request(make_draw(32'd10));
      send_request(make_modulate(31'd1));
      send_request(make_draw(32'd10));
      wait_drained();
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      csr_write(ADDR_FALLBACK, 32'($urandom_range(32'h7FFF_FFFF, 1)));
      csr_write(ADDR_SEED, ($urandom_range(7) == 0) ? 32'd0 : $urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 2) send_request(make_modulate(31'($urandom)));
         else send_request(make_draw(random_range()));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 600;
      for (int i = 0; i < 20; i++) send_request(make_draw(random_range()));
      // Pause until everything is back, then go on.
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      for (int i = 0; i < 10; i++) send_request(make_draw(random_range()));
      wait_drained();
   endtask

   initial begin
      pr_seed = 31'd1;
      pr_fallback = 31'd1;
      pr_gen_one = 0;
      pr_gen_two = 0;
      pr_out = 0;
      pr_init_pending = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 23, 52);
      test_random(300, 52, 23);
      test_backpressure();
      test_random(300, 0, 0);
      $display("Covered %0d checked draws and %0d modulates over several seeds,",
               draws_checked, modulates_sent);
      $display("including zero seeds, modulus seeds, zero ranges and long result stalls.");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Timeout with %0d results outstanding", expected_draws.size());
      $display("Verification failed");
      $finish;
   end

endmodule
